// ===== rtl/core/thsf_pkg.sv =====
`default_nettype none

package thsf_pkg;

   localparam int NUM_CORNERS = 8;
   localparam int CORNER_BITS = 3;

   typedef logic [CORNER_BITS-1:0] thsf_node_type;

   // Bit k holds the sign of corner k along one axis: 1 is plus, 0 is minus.
   localparam logic [NUM_CORNERS-1:0] CORNER_SU = 8'b0110_0110;
   localparam logic [NUM_CORNERS-1:0] CORNER_SV = 8'b1100_1100;
   localparam logic [NUM_CORNERS-1:0] CORNER_SW = 8'b1111_0000;

   localparam thsf_node_type LAST_NODE = thsf_node_type'(NUM_CORNERS - 1);

   typedef struct packed {
      logic signed [15:0] u;
      logic signed [15:0] v;
      logic signed [15:0] w;
   } thsf_req_type;

   typedef struct packed {
      logic [2:0]         node;
      logic [15:0]        shape_value;
      logic signed [15:0] d_du;
      logic signed [15:0] d_dv;
      logic signed [15:0] d_dw;
      logic               last;
   } thsf_rsp_type;

   typedef struct packed {
      thsf_node_type node;
      logic          su;
      logic          sv;
      logic          sw;
      logic          last;
   } thsf_corner_type;

endpackage

`default_nettype wire

// ===== rtl/core/thsf_expand.sv =====
`default_nettype none

module thsf_expand #(
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  thsf_pkg::thsf_req_type       req_payload,
   output logic                         slot_valid,
   input  logic                         slot_ready,
   output logic [COORD_FRAC_BITS+1:0]   slot_fu,
   output logic [COORD_FRAC_BITS+1:0]   slot_fv,
   output logic [COORD_FRAC_BITS+1:0]   slot_fw,
   output thsf_pkg::thsf_corner_type    slot_corner
);
   import thsf_pkg::*;

   localparam int FW = COORD_FRAC_BITS + 2;
   localparam int CW = (FW > 17) ? FW : 17;
   localparam logic signed [CW-1:0] ONE = CW'(1) << COORD_FRAC_BITS;

   logic          hold_valid_ff, hold_valid_in;
   thsf_node_type count_ff, count_in;
   logic [FW-1:0] plus_ff [3];
   logic [FW-1:0] minus_ff [3];
   logic [FW-1:0] plus_in [3];
   logic [FW-1:0] minus_in [3];
   logic signed [15:0] coord [3];
   logic          take;
   logic          issue;
   logic          last_slot;

   function automatic logic signed [CW-1:0] clamp_coord(input logic signed [15:0] x);
      logic signed [CW-1:0] xe;
      xe = {{(CW-16){x[15]}}, x};
      if (xe > ONE) begin
         xe = ONE;
      end else if (xe < -ONE) begin
         xe = -ONE;
      end
      return xe;
   endfunction

   always_comb begin
      logic signed [CW-1:0] c;
      coord[0] = req_payload.u;
      coord[1] = req_payload.v;
      coord[2] = req_payload.w;
      for (int i = 0; i < 3; i++) begin
         c           = clamp_coord(coord[i]);
         plus_in[i]  = FW'(ONE + c);
         minus_in[i] = FW'(ONE - c);
      end
   end

   assign last_slot = (count_ff == LAST_NODE);
   assign issue     = hold_valid_ff && slot_ready;
   assign req_ready = !hold_valid_ff || (slot_ready && last_slot);
   assign take      = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      count_in      = count_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         count_in      = '0;
      end else if (issue) begin
         count_in = count_ff + thsf_node_type'(1);
         if (last_slot) begin
            hold_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         plus_ff  <= plus_in;
         minus_ff <= minus_in;
      end
   end

   assign slot_valid       = hold_valid_ff;
   assign slot_corner.node = count_ff;
   assign slot_corner.su   = CORNER_SU[count_ff];
   assign slot_corner.sv   = CORNER_SV[count_ff];
   assign slot_corner.sw   = CORNER_SW[count_ff];
   assign slot_corner.last = last_slot;
   assign slot_fu = CORNER_SU[count_ff] ? plus_ff[0] : minus_ff[0];
   assign slot_fv = CORNER_SV[count_ff] ? plus_ff[1] : minus_ff[1];
   assign slot_fw = CORNER_SW[count_ff] ? plus_ff[2] : minus_ff[2];

   a_slot_hold: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !slot_ready |=> hold_valid_ff && $stable(count_ff))
      else $error("Corner sequencer advanced without a transaction.");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      issue && last_slot && !take |=> !hold_valid_ff)
      else $error("Corner sequencer kept running after the last corner.");

endmodule

`default_nettype wire

// ===== rtl/core/thsf_pipe.sv =====
`default_nettype none

module thsf_pipe #(
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         slot_valid,
   output logic                         slot_ready,
   input  logic [COORD_FRAC_BITS+1:0]   slot_fu,
   input  logic [COORD_FRAC_BITS+1:0]   slot_fv,
   input  logic [COORD_FRAC_BITS+1:0]   slot_fw,
   input  thsf_pkg::thsf_corner_type    slot_corner,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output thsf_pkg::thsf_rsp_type       rsp_payload
);
   import thsf_pkg::*;

   localparam int FW = COORD_FRAC_BITS + 2;
   localparam int PW = 2 * COORD_FRAC_BITS + 3;
   localparam int PL = (PW + 1) / 2;
   localparam int PH = PW - PL;
   localparam int TW = PW + FW;
   localparam int S2 = 2 * COORD_FRAC_BITS - 12;
   localparam int S3 = 3 * COORD_FRAC_BITS - 12;
   localparam logic [PW:0]   HALF2 = (PW + 1)'(1) << (S2 - 1);
   localparam logic [TW-1:0] HALF3 = TW'(1) << (S3 - 1);

   logic            s2_valid_ff;
   thsf_corner_type s2_corner_ff;
   logic [PW-1:0]   s2_puv_ff, s2_pvw_ff, s2_puw_ff;
   logic [PW-1:0]   s2_puv_in, s2_pvw_in, s2_puw_in;
   logic [FW-1:0]   s2_fw_ff;

   logic             s3_valid_ff;
   thsf_corner_type  s3_corner_ff;
   logic [PL+FW-1:0] s3_lo_ff, s3_lo_in;
   logic [PH+FW-1:0] s3_hi_ff, s3_hi_in;
   logic [15:0]      s3_du_ff, s3_dv_ff, s3_dw_ff;
   logic [15:0]      s3_du_in, s3_dv_in, s3_dw_in;

   logic         out_valid_ff;
   thsf_rsp_type out_ff, out_in;

   logic s2_ready, s3_ready, s4_ready;
   logic [TW-1:0] total;

   function automatic logic [15:0] round_deriv(input logic [PW-1:0] m, input logic positive);
      logic [PW:0] up;
      logic [PW:0] down;
      logic [15:0] r;
      up   = {1'b0, m} + HALF2;
      down = {1'b0, m} + (HALF2 - (PW + 1)'(1));
      if (positive) begin
         r = up[S2+15:S2];
      end else begin
         r = -down[S2+15:S2];
      end
      return r;
   endfunction

   assign s4_ready   = !out_valid_ff || rsp_ready;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign slot_ready = s2_ready;

   always_comb begin
      logic [2*FW-1:0] puv, pvw, puw;
      puv       = slot_fu * slot_fv;
      pvw       = slot_fv * slot_fw;
      puw       = slot_fu * slot_fw;
      s2_puv_in = puv[PW-1:0];
      s2_pvw_in = pvw[PW-1:0];
      s2_puw_in = puw[PW-1:0];
   end

   always_comb begin
      s3_lo_in = s2_puv_ff[PL-1:0] * s2_fw_ff;
      s3_hi_in = s2_puv_ff[PW-1:PL] * s2_fw_ff;
      s3_du_in = round_deriv(s2_pvw_ff, s2_corner_ff.su);
      s3_dv_in = round_deriv(s2_puw_ff, s2_corner_ff.sv);
      s3_dw_in = round_deriv(s2_puv_ff, s2_corner_ff.sw);
   end

   always_comb begin
      total              = {s3_hi_ff, {PL{1'b0}}} + TW'(s3_lo_ff) + HALF3;
      out_in.node        = s3_corner_ff.node;
      out_in.shape_value = total[S3+15:S3];
      out_in.d_du        = s3_du_ff;
      out_in.d_dv        = s3_dv_ff;
      out_in.d_dw        = s3_dw_ff;
      out_in.last        = s3_corner_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= slot_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && slot_valid) begin
         s2_corner_ff <= slot_corner;
         s2_puv_ff    <= s2_puv_in;
         s2_pvw_ff    <= s2_pvw_in;
         s2_puw_ff    <= s2_puw_in;
         s2_fw_ff     <= slot_fw;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_corner_ff <= s2_corner_ff;
         s3_lo_ff     <= s3_lo_in;
         s3_hi_ff     <= s3_hi_in;
         s3_du_ff     <= s3_du_in;
         s3_dv_ff     <= s3_dv_in;
         s3_dw_ff     <= s3_dw_in;
      end
      if (s4_ready && s3_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_last_node: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.last == (out_ff.node == LAST_NODE))
      else $error("Last flag does not match the corner index.");

   a_shape_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.shape_value <= 16'd32768)
      else $error("Shape value exceeds one.");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s4_ready |=> s3_valid_ff && $stable(s3_corner_ff))
      else $error("Stalled pipeline stage lost or changed its corner.");

endmodule

`default_nettype wire

// ===== rtl/core/trilinear_hex_shape_functions.sv =====
`default_nettype none

// Trilinear shape functions of the eight-node reference hexahedron. Each
// request transaction carries one local coordinate (u,v,w) in signed fixed
// point with COORD_FRAC_BITS fraction bits; each coordinate is clamped to
// [-1,1]. The block answers with eight response transactions, one per
// corner in the order (-,-,-),(+,-,-),(+,+,-),(-,+,-),(-,-,+),(+,-,+),
// (+,+,+),(-,+,+), each with the corner index, the shape value in unsigned
// Q1.15, its three partial derivatives in signed Q1.15 (round to nearest,
// ties up) and a last flag on the eighth. The corner sequencer registers
// the coordinate and feeds one corner per cycle, while slot_ready is high,
// into the three-stage arithmetic pipeline, whose output register holds the
// response; responses follow one per cycle while rsp_ready is high. The
// next coordinate is taken in the same cycle as the last corner of the
// previous one leaves the sequencer, and no earlier.
module trilinear_hex_shape_functions #(
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  thsf_pkg::thsf_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output thsf_pkg::thsf_rsp_type rsp_payload
);
   import thsf_pkg::*;

   logic                       slot_valid;
   logic                       slot_ready;
   logic [COORD_FRAC_BITS+1:0] slot_fu;
   logic [COORD_FRAC_BITS+1:0] slot_fv;
   logic [COORD_FRAC_BITS+1:0] slot_fw;
   thsf_corner_type            slot_corner;

   thsf_expand #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_expand (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .slot_valid (slot_valid),
      .slot_ready (slot_ready),
      .slot_fu    (slot_fu),
      .slot_fv    (slot_fv),
      .slot_fw    (slot_fw),
      .slot_corner(slot_corner)
   );

   thsf_pipe #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (slot_valid),
      .slot_ready (slot_ready),
      .slot_fu    (slot_fu),
      .slot_fv    (slot_fv),
      .slot_fw    (slot_fw),
      .slot_corner(slot_corner),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import thsf_pkg::*;

   localparam int FRAC_BITS    = 14;
   localparam int UNIT         = 1 << FRAC_BITS;
   localparam int SHAPE_SHIFT  = 3 * FRAC_BITS - 12;
   localparam int DERIV_SHIFT  = 2 * FRAC_BITS - 12;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 100;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   thsf_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   thsf_rsp_type rsp_payload;

   thsf_rsp_type expected_corners[$];
   thsf_rsp_type want;
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           req_idle_enable = 1'b0;
   bit           rsp_idle_enable = 1'b0;
   int           rsp_stall_left = 0;
   int           rsp_hold_request = 0;
   int           rsp_hold_left = 0;

   trilinear_hex_shape_functions #(
      .COORD_FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint unsigned clamp_coord(logic signed [15:0] raw, bit plus_side);
      int x;
      x = int'(raw);
      if (x > UNIT) x = UNIT;
      if (x < -UNIT) x = -UNIT;
      return plus_side ? longint'(UNIT + x) : longint'(UNIT - x);
   endfunction

   function automatic logic [15:0] round_partial(longint unsigned m, bit positive);
      longint unsigned half;
      half = longint'(1) << (DERIV_SHIFT - 1);
      if (positive) return 16'((m + half) >> DERIV_SHIFT);
      return 16'(-((m + half - 1) >> DERIV_SHIFT));
   endfunction

   function automatic void predict_corners(thsf_req_type c);
      longint unsigned fu;
      longint unsigned fv;
      longint unsigned fw;
      thsf_rsp_type    r;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         fu = clamp_coord(c.u, CORNER_SU[k]);
         fv = clamp_coord(c.v, CORNER_SV[k]);
         fw = clamp_coord(c.w, CORNER_SW[k]);
         r.node = thsf_node_type'(k);
         r.shape_value = 16'((fu * fv * fw + (longint'(1) << (SHAPE_SHIFT - 1))) >> SHAPE_SHIFT);
         r.d_du = round_partial(fv * fw, CORNER_SU[k]);
         r.d_dv = round_partial(fu * fw, CORNER_SV[k]);
         r.d_dw = round_partial(fu * fv, CORNER_SW[k]);
         r.last = (thsf_node_type'(k) == LAST_NODE);
         expected_corners.push_back(r);
      end
   endfunction

   function automatic logic signed [15:0] random_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'($urandom);
      if (pick == 1) begin
         case ($urandom_range(0, 4))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
         endcase
      end
      return 16'($urandom_range(0, 2 * UNIT) - UNIT);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_corners.size() == 0) begin
            $error("unexpected response transaction for node %0d", rsp_payload.node);
            fail_count++;
         end else begin
            want = expected_corners.pop_front();
            if (rsp_payload.node !== want.node) begin
               $error("node: expected %0d, actual %0d", want.node, rsp_payload.node);
               fail_count++;
            end
            if (rsp_payload.shape_value !== want.shape_value) begin
               $error("shape_value: expected %0d, actual %0d",
                      want.shape_value, rsp_payload.shape_value);
               fail_count++;
            end
            if (rsp_payload.d_du !== want.d_du) begin
               $error("d_du: expected %0d, actual %0d", want.d_du, rsp_payload.d_du);
               fail_count++;
            end
            if (rsp_payload.d_dv !== want.d_dv) begin
               $error("d_dv: expected %0d, actual %0d", want.d_dv, rsp_payload.d_dv);
               fail_count++;
            end
            if (rsp_payload.d_dw !== want.d_dw) begin
               $error("d_dw: expected %0d, actual %0d", want.d_dw, rsp_payload.d_dw);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_coord(input logic signed [15:0] u, input logic signed [15:0] v,
                             input logic signed [15:0] w);
      thsf_req_type c;
      c.u = u;
      c.v = v;
      c.w = w;
      @(negedge clock);
      if (req_idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= c;
      do @(posedge clock); while (!req_ready);
      predict_corners(c);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_corners.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_coord(-16'sd16384, -16'sd16384, -16'sd16384);
      send_coord(16'sd16384, 16'sd16384, 16'sd16384);
      send_coord(16'sd0, 16'sd0, 16'sd0);
      send_coord(16'sd16384, -16'sd16384, 16'sd0);
      send_coord(-16'sd16384, 16'sd0, 16'sd16384);
      send_coord(16'sd32767, -16'sd32768, 16'sd16385);
      send_coord(-16'sd16385, 16'sd32767, -16'sd32768);
      send_coord(16'sd1, -16'sd1, 16'sd1);
      send_coord(-16'sd1, 16'sd1, -16'sd1);
      send_coord(16'sd8192, -16'sd8192, 16'sd8192);
      send_coord(16'sd16383, -16'sd16383, 16'sd3);
      send_coord(-16'sd21845, 16'sd5461, -16'sd10923);
      send_coord(16'sd2, 16'sd6, -16'sd2);
      send_coord(-16'sd16383, -16'sd1, 16'sd16383);
      send_coord(16'sh5555, 16'shAAAA, 16'sh7FFF);
      send_coord(16'sh8000, 16'sh4000, 16'shC000);
      send_coord(16'sh2AAA, -16'sh2AAA, 16'sh1555);
      send_coord(16'sd12345, -16'sd4321, 16'sd777);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_coord(random_coord(), random_coord(), random_coord());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      @(posedge clock);
      rsp_hold_request = 300;
      for (int i = 0; i < 10; i++) begin
         send_coord(random_coord(), random_coord(), random_coord());
      end
      wait_drained();
   endtask

   task automatic test_steady_stream();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      for (int i = 0; i < 20; i++) begin
         send_coord(random_coord(), random_coord(), random_coord());
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/thsf_pkg.sv
rtl/core/thsf_expand.sv
rtl/core/thsf_pipe.sv
rtl/core/trilinear_hex_shape_functions.sv
test/tb_top.sv
